// File: hw/rtl/srum_pkg.sv
// ----------------------------------------------------------------------------
// srum_pkg
// Shared types and codes for the sparse row union merge block.
// ----------------------------------------------------------------------------
package srum_pkg;

  localparam int COL_W        = 24;
  localparam int VAL_W        = 64;
  localparam int ROW_CAP_DEF  = 32;
  localparam int COL_BITS_DEF = 24;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  typedef struct packed {
    logic                    source;
    logic                    has_entry;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
  } in_beat_t;

  typedef struct packed {
    logic                    entry_present;
    logic [COL_W-1:0]        out_column;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
    logic                    overflow;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic [1:0]       op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } alu_req_t;

endpackage

// File: hw/rtl/sparse_row_union_merge.sv
// ----------------------------------------------------------------------------
// sparse_row_union_merge
// Elementwise add/sub/multiply of two sparse rows over the union of columns.
// ----------------------------------------------------------------------------
//  channel  | ports                         | beat
//  ---------+-------------------------------+------------------------------
//  input    | in_valid/in_ready/in_data     | one row entry or row-end mark
//  result   | out_valid/out_ready/out_data  | one nonzero result or marker
//  config   | cfg_we/cfg_wdata              | operation code, no handshake
//
//  Load: one input beat per cycle while rows fill; in_ready is low from the
//  beat that ends the second row until the last result is in the output reg.
//  Merge: each union column goes through read, compare and execute; multiply
//  runs three passes on the shared 32x32 multiplier. Read and finish close a row.
//  Results leave through a one-deep output register; a held result stalls the
//  merge only when the next one is ready to be pushed.
//  Reset (rst_n low, synchronous) empties both rows and sets operation to add.
// ----------------------------------------------------------------------------
module sparse_row_union_merge #(
  parameter int ROW_CAPACITY = srum_pkg::ROW_CAP_DEF,
  parameter int COLUMN_BITS  = srum_pkg::COL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srum_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srum_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata
);
  import srum_pkg::*;

  localparam int CNT_W = $clog2(ROW_CAPACITY + 1);
  localparam int IDX_W = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
  localparam int CB    = COLUMN_BITS;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(ROW_CAPACITY);

  localparam logic [2:0] ST_LOAD = 3'd0;  // taking row entries
  localparam logic [2:0] ST_RD   = 3'd1;  // read heads of both rows
  localparam logic [2:0] ST_CMP  = 3'd2;  // pick column, start ALU
  localparam logic [2:0] ST_EXE  = 3'd3;  // wait result, stage it
  localparam logic [2:0] ST_FIN  = 3'd4;  // push final beat, clear row

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       op_r;
  logic [CNT_W-1:0] fc_r, fc_nxt, sc_r, sc_nxt;   // stored entry counts
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;       // merge heads
  logic             fd_r, fd_nxt, sd_r, sd_nxt;   // row ended flags
  logic             drop_r, drop_nxt;

  // pending result: held back until we know whether it is the last one
  logic             pend_v_r, pend_v_nxt;
  logic [CB-1:0]    pend_col_r, pend_col_nxt;
  logic [VAL_W-1:0] pend_val_r, pend_val_nxt;
  logic [CB-1:0]    cand_col_r, cand_col_nxt;

  logic             out_v_r, out_v_nxt;
  out_beat_t        out_r, out_nxt;

  logic             in_acc, slot_free;
  logic             row_done, store_ok;
  logic [CB-1:0]    col_in;
  logic             f_we, s_we;
  logic [CB-1:0]    fcol, scol;
  logic [VAL_W-1:0] fval, sval;
  logic             a_ok, b_ok, take_a, take_b;
  alu_req_t         alu_req;
  logic             alu_busy;
  logic [VAL_W-1:0] alu_res;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_v_r || out_ready;
  assign col_in    = CB'(in_data.column);
  assign row_done  = in_data.source ? sd_r : fd_r;
  assign store_ok  = in_acc && !row_done && in_data.has_entry && (in_data.value != '0);
  assign f_we      = store_ok && !in_data.source && (fc_r < CAP);
  assign s_we      = store_ok && in_data.source && (sc_r < CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_ADD;
    end else if (cfg_we) begin
      op_r <= cfg_wdata;
    end
  end

  srum_row_buf #(.DEPTH(ROW_CAPACITY), .CB(CB), .IDX_W(IDX_W)) u_first (
    .clk   (clk),
    .we    (f_we),
    .waddr (fc_r[IDX_W-1:0]),
    .wcol  (col_in),
    .wval  (in_data.value),
    .raddr (i_r[IDX_W-1:0]),
    .rcol  (fcol),
    .rval  (fval)
  );

  srum_row_buf #(.DEPTH(ROW_CAPACITY), .CB(CB), .IDX_W(IDX_W)) u_second (
    .clk   (clk),
    .we    (s_we),
    .waddr (sc_r[IDX_W-1:0]),
    .wcol  (col_in),
    .wval  (in_data.value),
    .raddr (j_r[IDX_W-1:0]),
    .rcol  (scol),
    .rval  (sval)
  );

  // head selection: smaller column first, equal columns combine
  assign a_ok   = i_r < fc_r;
  assign b_ok   = j_r < sc_r;
  assign take_a = a_ok && (!b_ok || !(scol < fcol));
  assign take_b = b_ok && (!a_ok || !(fcol < scol));

  always_comb begin
    alu_req.start = (state_r == ST_CMP);
    alu_req.op    = op_r;
    alu_req.a     = take_a ? fval : '0;
    alu_req.b     = take_b ? sval : '0;
  end

  srum_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .busy  (alu_busy),
    .res   (alu_res)
  );

  always_comb begin
    state_nxt    = state_r;
    fc_nxt       = fc_r;
    sc_nxt       = sc_r;
    fd_nxt       = fd_r;
    sd_nxt       = sd_r;
    drop_nxt     = drop_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    pend_v_nxt   = pend_v_r;
    pend_col_nxt = pend_col_r;
    pend_val_nxt = pend_val_r;
    cand_col_nxt = cand_col_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_nxt      = out_r;

    case (state_r)
      ST_LOAD: begin
        if (in_acc && !row_done) begin
          if (f_we) fc_nxt = fc_r + 1'b1;
          if (s_we) sc_nxt = sc_r + 1'b1;
          if (store_ok && !f_we && !s_we) drop_nxt = 1'b1;
          if (in_data.row_end) begin
            if (in_data.source) sd_nxt = 1'b1;
            else                fd_nxt = 1'b1;
          end
          if ((fd_nxt && sd_nxt)) begin
            i_nxt      = '0;
            j_nxt      = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = (a_ok || b_ok) ? ST_CMP : ST_FIN;
      end
      ST_CMP: begin
        cand_col_nxt = take_a ? fcol : scol;
        if (take_a) i_nxt = i_r + 1'b1;
        if (take_b) j_nxt = j_r + 1'b1;
        state_nxt = ST_EXE;
      end
      ST_EXE: begin
        if (!alu_busy) begin
          if (alu_res == '0) begin
            state_nxt = ST_RD;
          end else if (!pend_v_r) begin
            pend_v_nxt   = 1'b1;
            pend_col_nxt = cand_col_r;
            pend_val_nxt = alu_res;
            state_nxt    = ST_RD;
          end else if (slot_free) begin
            out_v_nxt             = 1'b1;
            out_nxt.entry_present = 1'b1;
            out_nxt.out_column    = COL_W'(pend_col_r);
            out_nxt.out_value     = pend_val_r;
            out_nxt.last          = 1'b0;
            out_nxt.overflow      = drop_r;
            pend_col_nxt          = cand_col_r;
            pend_val_nxt          = alu_res;
            state_nxt             = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_v_nxt             = 1'b1;
          out_nxt.entry_present = pend_v_r;
          out_nxt.out_column    = pend_v_r ? COL_W'(pend_col_r) : '0;
          out_nxt.out_value     = pend_v_r ? pend_val_r : '0;
          out_nxt.last          = 1'b1;
          out_nxt.overflow      = drop_r;
          pend_v_nxt            = 1'b0;
          fc_nxt                = '0;
          sc_nxt                = '0;
          fd_nxt                = 1'b0;
          sd_nxt                = 1'b0;
          drop_nxt              = 1'b0;
          state_nxt             = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      fc_r     <= '0;
      sc_r     <= '0;
      fd_r     <= 1'b0;
      sd_r     <= 1'b0;
      drop_r   <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fc_r     <= fc_nxt;
      sc_r     <= sc_nxt;
      fd_r     <= fd_nxt;
      sd_r     <= sd_nxt;
      drop_r   <= drop_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_col_r <= pend_col_nxt;
    pend_val_r <= pend_val_nxt;
    cand_col_r <= cand_col_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // counts never pass row capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (fc_r <= CAP) && (sc_r <= CAP))
    else $error("row count above capacity");

  // merge heads never pass the ends of the stored rows
  a_heads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> ((i_r <= fc_r) && (j_r <= sc_r)))
    else $error("merge head past row end");

  // no result held over while loading a new row
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> !pend_v_r)
    else $error("pending result left in load");

  // closing a row always puts a last beat in the output register
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && slot_free) |=> (out_valid && out_data.last))
    else $error("row closed without last beat");

  // ALU is never started while a multiply is running
  a_alu: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> !alu_busy)
    else $error("ALU started while busy");

endmodule

// File: hw/rtl/srum_row_buf.sv
// ----------------------------------------------------------------------------
// srum_row_buf
// Entry store for one operand row: column and value per slot, registered read.
// ----------------------------------------------------------------------------
module srum_row_buf #(
  parameter int DEPTH  = 32,
  parameter int CB     = 24,
  parameter int IDX_W  = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [IDX_W-1:0]         waddr,
  input  logic [CB-1:0]            wcol,
  input  logic [srum_pkg::VAL_W-1:0] wval,
  input  logic [IDX_W-1:0]         raddr,
  output logic [CB-1:0]            rcol,
  output logic [srum_pkg::VAL_W-1:0] rval
);
  import srum_pkg::*;

  logic [CB+VAL_W-1:0] mem [DEPTH];
  logic [CB+VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wcol, wval};
    end
    rdata_r <= mem[raddr];
  end

  assign rcol = rdata_r[CB+VAL_W-1:VAL_W];
  assign rval = rdata_r[VAL_W-1:0];

endmodule

// File: hw/rtl/srum_alu.sv
// ----------------------------------------------------------------------------
// srum_alu
// Shared 64-bit add/sub/multiply unit; multiply is three 32x32 partial
// products through one multiplier, low 64 bits kept.
// ----------------------------------------------------------------------------
module srum_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  srum_pkg::alu_req_t         req,
  output logic                       busy,
  output logic [srum_pkg::VAL_W-1:0] res
);
  import srum_pkg::*;

  localparam int HW = VAL_W / 2;

  logic [VAL_W-1:0] a_r, b_r, acc_r, acc_nxt, prod_r, prod_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [HW-1:0]    mul_a, mul_b;
  logic             is_mul;

  assign is_mul = (req.op != OP_ADD) && (req.op != OP_SUB);

  // operand select for the single multiplier
  always_comb begin
    if (!busy_r) begin
      mul_a = req.a[HW-1:0];
      mul_b = req.b[HW-1:0];
    end else if (cnt_r == 2'd0) begin
      mul_a = a_r[HW-1:0];
      mul_b = b_r[VAL_W-1:HW];
    end else begin
      mul_a = a_r[VAL_W-1:HW];
      mul_b = b_r[HW-1:0];
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      prod_nxt = VAL_W'(mul_a) * VAL_W'(mul_b);
      cnt_nxt  = cnt_r + 2'd1;
      case (cnt_r)
        2'd0: acc_nxt = prod_r;
        2'd1: acc_nxt = acc_r + {prod_r[HW-1:0], {HW{1'b0}}};
        default: begin
          acc_nxt  = acc_r + {prod_r[HW-1:0], {HW{1'b0}}};
          busy_nxt = 1'b0;
        end
      endcase
    end else if (req.start) begin
      case (req.op)
        OP_ADD: acc_nxt = req.a + req.b;
        OP_SUB: acc_nxt = req.a - req.b;
        default: begin
          prod_nxt = VAL_W'(mul_a) * VAL_W'(mul_b);
          cnt_nxt  = 2'd0;
          busy_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (req.start && !busy_r && is_mul) begin
      a_r <= req.a;
      b_r <= req.b;
    end
  end

  assign busy = busy_r;
  assign res  = acc_r;

endmodule

// File: tb/sv/tb_sparse_row_union_merge.sv
// ----------------------------------------------------------------------------
// tb_sparse_row_union_merge
// Self-checking bench for the sparse row union merge block. Row pairs are fed
// through the input channel and every result beat is checked against a
// behavioral merge of the same rows, under every operation code.
// ----------------------------------------------------------------------------
module tb_sparse_row_union_merge;
  timeunit 1ns;
  timeprecision 1ps;

  import srum_pkg::*;

  // code 3 is not named in the package; the block treats it as multiply
  localparam logic [1:0] OP_MUL_ALT = 2'd3;
  localparam int         ROW_CAP    = ROW_CAP_DEF;
  localparam logic [63:0] VAL_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [23:0] COL_TOP   = 24'hFF_FFFF;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = OP_ADD;

  sparse_row_union_merge i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  in_beat_t  pending_beats[$];   // input beats not yet offered
  out_beat_t due_results[$];     // predicted result beats, oldest first
  int        stim_beats    = 0;  // input beats queued, ignored ones excluded
  int        mismatches    = 0;
  bit        in_took       = 1'b0;
  bit        out_took      = 1'b0;
  bit        drv_active    = 1'b0;
  int        send_gap      = 0;
  int        send_gap_max  = 0;
  int        recv_gap      = 0;
  int        recv_gap_max  = 0;
  int        hold_off_req  = 0;  // set by the sequence, consumed by receiver
  int        hold_left     = 0;

  // --------------------------------------------------------------------------
  // Merge predictor: its own copy of the operation and of both rows
  // --------------------------------------------------------------------------
  logic [1:0]  pred_op = OP_ADD;
  logic [23:0] first_cols  [ROW_CAP];
  logic [63:0] first_vals  [ROW_CAP];
  logic [23:0] second_cols [ROW_CAP];
  logic [63:0] second_vals [ROW_CAP];
  int          first_cnt   = 0;
  int          second_cnt  = 0;
  bit          first_end   = 1'b0;
  bit          second_end  = 1'b0;
  bit          row_dropped = 1'b0;

  function automatic logic [63:0] apply_op(logic [63:0] x, logic [63:0] y);
    case (pred_op)
      OP_ADD:  return x + y;
      OP_SUB:  return x - y;
      default: return x * y;   // multiply and the spare code
    endcase
  endfunction

  // One accepted input beat; pushes the row's results once both rows closed.
  task automatic merge_row_step(input in_beat_t b);
    out_beat_t   row_res[$];
    out_beat_t   r;
    logic [63:0] x, y, v;
    logic [23:0] c;
    int          i, j;
    i = 0;
    j = 0;
    // a row that already ended ignores everything until the merge
    if (b.source ? second_end : first_end) return;
    if (b.has_entry && b.value != 0) begin
      if (b.source) begin
        if (second_cnt < ROW_CAP) begin
          second_cols[second_cnt] = b.column;
          second_vals[second_cnt] = b.value;
          second_cnt++;
        end else begin
          row_dropped = 1'b1;
        end
      end else begin
        if (first_cnt < ROW_CAP) begin
          first_cols[first_cnt] = b.column;
          first_vals[first_cnt] = b.value;
          first_cnt++;
        end else begin
          row_dropped = 1'b1;
        end
      end
    end
    if (b.row_end) begin
      if (b.source) second_end = 1'b1;
      else first_end = 1'b1;
    end
    if (!(first_end && second_end)) return;

    // walk both heads, smaller column first, equal columns combine
    while (i < first_cnt || j < second_cnt) begin
      x = '0;
      y = '0;
      if (j >= second_cnt || (i < first_cnt && first_cols[i] < second_cols[j])) begin
        c = first_cols[i];
        x = first_vals[i];
        i++;
      end else if (i >= first_cnt || second_cols[j] < first_cols[i]) begin
        c = second_cols[j];
        y = second_vals[j];
        j++;
      end else begin
        c = first_cols[i];
        x = first_vals[i];
        y = second_vals[j];
        i++;
        j++;
      end
      v = apply_op(x, y);
      if (v != 0) begin
        r.entry_present = 1'b1;
        r.out_column    = c;
        r.out_value     = v;
        r.last          = 1'b0;
        r.overflow      = row_dropped;
        row_res = {row_res, r};
      end
    end
    if (row_res.size() == 0) begin
      // nothing survived: a single empty-row marker
      r = '0;
      r.last     = 1'b1;
      r.overflow = row_dropped;
      row_res = {row_res, r};
    end else begin
      row_res[row_res.size() - 1].last = 1'b1;
    end
    due_results = {due_results, row_res};
    first_cnt   = 0;
    second_cnt  = 0;
    first_end   = 1'b0;
    second_end  = 1'b0;
    row_dropped = 1'b0;
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    bit        bad;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: present=%0b col=%h val=%h last=%0b ovf=%0b",
                 got.entry_present, got.out_column, got.out_value, got.last,
                 got.overflow);
      return;
    end
    want = due_results.pop_front();
    bad = (got.entry_present !== want.entry_present) ||
          (got.out_column    !== want.out_column)    ||
          (got.out_value     !== want.out_value)     ||
          (got.last          !== want.last)          ||
          (got.overflow      !== want.overflow);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  exp present=%0b col=%h val=%h last=%0b ovf=%0b",
                 want.entry_present, want.out_column, want.out_value, want.last,
                 want.overflow);
        $display("  got present=%0b col=%h val=%h last=%0b ovf=%0b",
                 got.entry_present, got.out_column, got.out_value, got.last,
                 got.overflow);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: samples both handshakes and config writes at the rising edge.
  // Input beats are predicted before result beats are checked, so a result
  // caused by the same edge could never be flagged early.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took  = 1'b0;
      out_took = 1'b0;
    end else begin
      if (cfg_we) pred_op = cfg_wdata;
      in_took = in_valid && in_ready;
      if (in_took) merge_row_step(in_data);
      out_took = out_valid && out_ready;
      if (out_took) check_result(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offers queued beats at the falling edge, random gap after each
  // accepted beat. Valid is computed once per edge, so a back-to-back beat
  // keeps valid high with a single assignment.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (drv_active && in_took) begin
        drv_active = 1'b0;
        send_gap   = $urandom_range(0, send_gap_max);
      end
      if (!drv_active) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_beats.size() > 0) begin
          in_data <= pending_beats.pop_front();
          drv_active = 1'b1;
        end
      end
      in_valid <= drv_active;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall after each result beat, plus a long hold-off on
  // request, counted here so the sender keeps pushing while results back up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) recv_gap = $urandom_range(0, recv_gap_max);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_beat_t mk_beat(bit src, bit has, logic [23:0] col,
                                       logic [63:0] val, bit row_end);
    in_beat_t b;
    b.source    = src;
    b.has_entry = has;
    b.column    = col;
    b.value     = val;
    b.row_end   = row_end;
    return b;
  endfunction

  // counted = 0 for beats the block is expected to ignore
  task automatic push_beat(input in_beat_t b, input bit counted);
    pending_beats = {pending_beats, b};
    if (counted) stim_beats++;
  endtask

  // mostly full-range, with zeros, small values (cancellation) and extremes
  function automatic logic [63:0] pick_value();
    int v;
    v = $urandom_range(0, 8) - 4;
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1, 2:    return {{32{v[31]}}, v};
      3:       return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      4:       return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_base();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 40);
      1:       return $urandom & 32'h00FF_FFFF;
      2:       return COL_TOP - $urandom_range(0, 300);
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  // One operand row; the end is either on the last entry or a separate mark.
  task automatic make_row(input bit src, input int n, input int unsigned base,
                          input int step_max, input bit shuffled,
                          output in_beat_t row[$]);
    int unsigned c;
    bit          sep_end;
    int          k;
    c       = base;
    row     = {};
    sep_end = (n == 0) || ($urandom_range(0, 3) == 0);
    for (k = 0; k < n; k++) begin
      // occasional no-op beat with junk column and value
      if ($urandom_range(0, 9) == 0)
        row = {row, mk_beat(src, 1'b0, 24'($urandom), {$urandom, $urandom}, 1'b0)};
      if (shuffled && $urandom_range(0, 3) == 0)
        row = {row, mk_beat(src, 1'b1, 24'(base + $urandom_range(0, 64)), pick_value(),
                            !sep_end && k == n - 1)};
      else
        row = {row, mk_beat(src, 1'b1, c[23:0], pick_value(), !sep_end && k == n - 1)};
      c += $urandom_range(1, step_max);
    end
    if (sep_end)
      row = {row, mk_beat(src, 1'b0, 24'($urandom), {$urandom, $urandom}, 1'b1)};
  endtask

  // Two rows sharing a base column so that ties are common, interleaved at
  // random. Once one row has ended, stray beats for it may follow; the block
  // must ignore them until the other row ends.
  task automatic queue_row_pair(input int n1, input int n2);
    in_beat_t    ra[$], rb[$];
    int unsigned base;
    int          step_max;
    bit          shuffled, strays;
    base     = pick_base();
    shuffled = ($urandom_range(0, 7) == 0);
    strays   = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0:       step_max = 1;
      1:       step_max = 2;
      2:       step_max = 4;
      default: step_max = 1000;
    endcase
    make_row(1'b0, n1, base, step_max, shuffled, ra);
    make_row(1'b1, n2, base, step_max, shuffled, rb);
    while (ra.size() > 0 || rb.size() > 0) begin
      if (rb.size() == 0 || (ra.size() > 0 && $urandom_range(0, 1)))
        push_beat(ra.pop_front(), 1'b1);
      else
        push_beat(rb.pop_front(), 1'b1);
      if (strays && ra.size() == 0 && rb.size() > 0 && $urandom_range(0, 2) == 0)
        push_beat(mk_beat(1'b0, 1'($urandom), 24'($urandom), pick_value(),
                          1'($urandom)), 1'b0);
      if (strays && rb.size() == 0 && ra.size() > 0 && $urandom_range(0, 2) == 0)
        push_beat(mk_beat(1'b1, 1'($urandom), 24'($urandom), pick_value(),
                          1'($urandom)), 1'b0);
    end
  endtask

  function automatic int pick_row_len();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(33, 40);  // past capacity
      1, 2:    return $urandom_range(9, 32);
      default: return $urandom_range(0, 8);
    endcase
  endfunction

  // extreme columns and values; the top column wraps to zero under add and
  // multiply and cancels under subtract
  task automatic queue_extremes_pair();
    push_beat(mk_beat(1'b0, 1'b1, 24'd0,   VAL_MAX, 1'b0), 1'b1);
    push_beat(mk_beat(1'b1, 1'b1, 24'd0,   64'd1,   1'b0), 1'b1);
    push_beat(mk_beat(1'b0, 1'b1, COL_TOP, VAL_MIN, 1'b1), 1'b1);
    push_beat(mk_beat(1'b1, 1'b1, COL_TOP, VAL_MIN, 1'b1), 1'b1);
  endtask

  function automatic bit block_idle();
    return pending_beats.size() == 0 && !drv_active && due_results.size() == 0;
  endfunction

  // Only written with nothing in flight. The block is back in load once its
  // last result is out; a short settle still precedes the write.
  task automatic set_operation(input logic [1:0] op);
    while (!block_idle()) @(posedge clk);
    repeat (24) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= op;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence: directed rows under add, then random phases over all codes
  // --------------------------------------------------------------------------
  initial begin : sequence_main
    logic [1:0] phase_ops [6];
    int         p;
    int         target;
    phase_ops[0] = OP_SUB;
    phase_ops[1] = OP_MUL;
    phase_ops[2] = OP_MUL_ALT;
    phase_ops[3] = OP_ADD;
    phase_ops[4] = OP_MUL;
    phase_ops[5] = OP_SUB;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_operation(OP_ADD);
    queue_extremes_pair();
    // both rows empty, ended by bare marks with junk fields
    push_beat(mk_beat(1'b0, 1'b0, COL_TOP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1), 1'b1);
    push_beat(mk_beat(1'b1, 1'b0, 24'd0,   64'd0,                   1'b1), 1'b1);
    // zero value skipped, no-op beat, stray beat after first row ended,
    // descending columns in the second row
    push_beat(mk_beat(1'b0, 1'b1, 24'd7, 64'd0, 1'b1), 1'b1);
    push_beat(mk_beat(1'b1, 1'b1, 24'd7, 64'd5, 1'b0), 1'b1);
    push_beat(mk_beat(1'b1, 1'b0, 24'h5A5A5A, 64'h1234_5678_9ABC_DEF0, 1'b0), 1'b1);
    push_beat(mk_beat(1'b0, 1'b1, 24'd9, 64'd9, 1'b1), 1'b0);
    push_beat(mk_beat(1'b1, 1'b1, 24'd3, -64'sd5, 1'b1), 1'b1);
    // exact cancellation leaves only the marker
    push_beat(mk_beat(1'b0, 1'b1, 24'd4, 64'd6,   1'b1), 1'b1);
    push_beat(mk_beat(1'b1, 1'b1, 24'd4, -64'sd6, 1'b1), 1'b1);
    // ties and single-sided columns
    push_beat(mk_beat(1'b0, 1'b1, 24'd1, 64'd2, 1'b0), 1'b1);
    push_beat(mk_beat(1'b1, 1'b1, 24'd2, 64'd5, 1'b0), 1'b1);
    push_beat(mk_beat(1'b0, 1'b1, 24'd3, 64'd4, 1'b1), 1'b1);
    push_beat(mk_beat(1'b1, 1'b1, 24'd3, 64'd1, 1'b1), 1'b1);

    target = stim_beats;
    for (p = 0; p < 6; p++) begin
      set_operation(phase_ops[p]);
      case ($urandom_range(0, 2))
        0:       send_gap_max = 0;
        1:       send_gap_max = 3;
        default: send_gap_max = 12;
      endcase
      case ($urandom_range(0, 2))
        0:       recv_gap_max = 0;
        1:       recv_gap_max = 3;
        default: recv_gap_max = 12;
      endcase
      if (p == 2) begin
        // long receiver stall with a busy sender: rows fill and input backs up
        send_gap_max = 0;
        hold_off_req = 400;
      end
      queue_extremes_pair();
      if (p % 2 == 0) queue_row_pair(36, $urandom_range(0, 40));
      target += 58;
      while (stim_beats < target) queue_row_pair(pick_row_len(), pick_row_len());
    end

    while (!block_idle()) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      if (due_results.size() != 0)
        $display("%0d result beats never arrived", due_results.size());
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("timeout with %0d beats queued, %0d results due", pending_beats.size(),
             due_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

// File: sparse_row_union_merge.f
hw/rtl/srum_pkg.sv
hw/rtl/srum_row_buf.sv
hw/rtl/srum_alu.sv
hw/rtl/sparse_row_union_merge.sv
tb/sv/tb_sparse_row_union_merge.sv
